>>> hdl/mtep_pkg.sv
package mtep_pkg;

  // Longest variable-length number, in bytes
  localparam int MAX_VLQ_BYTES = 4;

  localparam int NumW = 28;

  // Result kinds
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Event classes
  localparam logic [1:0] CLASS_CHAN  = 2'd0;
  localparam logic [1:0] CLASS_SYSEX = 2'd1;
  localparam logic [1:0] CLASS_META  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_RSTAT  = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd2;
  localparam logic [2:0] ERR_META_LEN  = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // Status bytes
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_ESCAPE    = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSTEM    = 8'hF0;
  localparam logic [3:0] ST_PROG_CHG  = 4'hC;
  localparam logic [3:0] ST_CHAN_PRES = 4'hD;

  // Meta types
  localparam logic [7:0] META_SEQ_NUM   = 8'h00;
  localparam logic [7:0] META_TEXT_LO   = 8'h01;
  localparam logic [7:0] META_TEXT_HI   = 8'h07;
  localparam logic [7:0] META_CHAN_PFX  = 8'h20;
  localparam logic [7:0] META_PORT      = 8'h21;
  localparam logic [7:0] META_EOT       = 8'h2F;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_SMPTE     = 8'h54;
  localparam logic [7:0] META_TIME_SIG  = 8'h58;
  localparam logic [7:0] META_KEY_SIG   = 8'h59;
  localparam logic [7:0] META_SEQ_SPEC  = 8'h7F;

  typedef struct packed {
    logic       known;
    logic       var_len;
    logic [2:0] len;
  } meta_info_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [1:0]      evclass;
    logic [7:0]      status;
    logic [7:0]      meta;
    logic [NumW-1:0] delta;
    logic [NumW-1:0] plen;
    logic [7:0]      pbyte;
    logic            last;
    logic            eot;
    logic [2:0]      err;
  } res_t;

  // Expected length of each known meta type
  function automatic meta_info_t meta_info(input logic [7:0] t);
    meta_info_t mi;
    mi = '{known: 1'b1, var_len: 1'b0, len: 3'd0};
    case (t) inside
      [META_TEXT_LO:META_TEXT_HI]: mi.var_len = 1'b1;
      META_SEQ_SPEC:               mi.var_len = 1'b1;
      META_SEQ_NUM:                mi.len = 3'd2;
      META_CHAN_PFX:               mi.len = 3'd1;
      META_PORT:                   mi.len = 3'd1;
      META_EOT:                    mi.len = 3'd0;
      META_TEMPO:                  mi.len = 3'd3;
      META_SMPTE:                  mi.len = 3'd5;
      META_TIME_SIG:               mi.len = 3'd4;
      META_KEY_SIG:                mi.len = 3'd2;
      default:                     mi.known = 1'b0;
    endcase
    return mi;
  endfunction

  // Data bytes of a channel message
  function automatic logic [1:0] chan_len(input logic [7:0] st);
    if (st[7:4] == ST_PROG_CHG || st[7:4] == ST_CHAN_PRES) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

  // Build one result; error results carry no length and no end-of-track flag
  function automatic res_t make_res(input logic [1:0] kind, input logic [1:0] evclass,
                                    input logic [7:0] status, input logic [7:0] meta,
                                    input logic [NumW-1:0] delta,
                                    input logic [NumW-1:0] plen, input logic [7:0] pbyte,
                                    input logic last, input logic [2:0] err);
    res_t r;
    r.kind    = kind;
    r.evclass = evclass;
    r.status  = status;
    r.meta    = meta;
    r.delta   = delta;
    r.plen    = (kind == KIND_ERROR) ? '0 : plen;
    r.pbyte   = pbyte;
    r.last    = last;
    r.eot     = (kind != KIND_ERROR) && (evclass == CLASS_META) && (meta == META_EOT);
    r.err     = err;
    return r;
  endfunction

endpackage

>>> hdl/midi_track_event_parser.sv
// Channel  Dir  tdata (low bit up)                          tuser           tlast
// in_      in   in_byte[7:0]                                 track_start     -
// out_     out  status, meta_type, delta_ticks, payload_len, result_kind,    last_of_event
//               payload_byte, track_end, error_code          event_class
//
// One byte is taken per cycle while in_tready is high; the parser state updates in
// the same cycle and its results go into a four-entry result queue. A data byte under
// running status causes two results and costs two output transfers. in_tready is low
// while the queue holds more than two results.
// Reset (rst_n low, synchronous) clears the parser and empties the queue.
module midi_track_event_parser #(
  parameter int MaxVlqBytes = mtep_pkg::MAX_VLQ_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte[7:0]
  input  logic [0:0]  in_tuser,   // track_start[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // status[7:0], meta_type[15:8], delta_ticks[43:16],
                                  // payload_length[71:44], payload_byte[79:72],
                                  // track_end[80], error_code[83:81], zero[87:84]
  output logic [3:0]  out_tuser,  // result_kind[1:0], event_class[3:2]
  output logic        out_tlast   // last_of_event
);
  import mtep_pkg::*;

  localparam int VlqCntW = $clog2(MaxVlqBytes + 1);

  typedef enum logic [2:0] {
    PH_DELTA, PH_STATUS, PH_MTYPE, PH_LEN, PH_DATA, PH_HALT
  } phase_t;

  phase_t              phase_r, phase_nxt, phase_e;
  logic [NumW-1:0]     delta_r, delta_nxt, delta_e;
  logic [VlqCntW-1:0]  vcnt_r, vcnt_nxt, vcnt_e;
  logic [7:0]          rstat_r, rstat_nxt, rstat_e;
  logic [1:0]          class_r, class_nxt, class_e;
  logic [7:0]          meta_r, meta_nxt, meta_e;
  logic [NumW-1:0]     left_r, left_nxt, left_e;
  logic [7:0]          cstat_r, cstat_nxt, cstat_e;
  logic [NumW-1:0]     elen_r, elen_nxt, elen_e;

  logic [7:0]          b;
  logic                accept;
  logic [1:0]          n_res;
  res_t                res0, res1;
  logic                end_ev;

  logic [NumW-1:0]     vlq_acc, vlq_new;
  logic                vlq_wide;
  logic                vlq_ovf;
  meta_info_t          mi;
  meta_info_t          mi_in;
  logic [1:0]          clen;
  logic [NumW-1:0]     left_dec;

  res_t                fifo_r [4];
  logic [1:0]          wr_ptr_r, rd_ptr_r;
  logic [2:0]          count_r;
  logic                pop;
  logic [1:0]          n_push;
  res_t                head;

  assign b      = in_tdata;
  assign accept = in_tvalid && in_tready;

  // Start of track clears everything before the byte is taken
  always_comb begin
    if (in_tuser[0]) begin
      phase_e = PH_DELTA;
      delta_e = '0;
      vcnt_e  = '0;
      rstat_e = '0;
      class_e = CLASS_CHAN;
      meta_e  = '0;
      left_e  = '0;
      cstat_e = '0;
      elen_e  = '0;
    end else begin
      phase_e = phase_r;
      delta_e = delta_r;
      vcnt_e  = vcnt_r;
      rstat_e = rstat_r;
      class_e = class_r;
      meta_e  = meta_r;
      left_e  = left_r;
      cstat_e = cstat_r;
      elen_e  = elen_r;
    end
  end

  // Shared variable-length number step
  assign vlq_acc  = (phase_e == PH_DELTA) ? delta_e : left_e;
  assign vlq_new  = {vlq_acc[NumW-8:0], b[6:0]};
  assign vlq_wide = (vlq_acc[NumW-1:NumW-7] != '0);
  assign vlq_ovf  = vlq_wide || (b[7] && (int'(vcnt_e) + 1 >= MaxVlqBytes));

  assign mi       = meta_info(meta_e);
  assign mi_in    = meta_info(b);
  assign left_dec = left_e - NumW'(1);

  // Decode one byte
  always_comb begin
    phase_nxt = phase_e;
    delta_nxt = delta_e;
    vcnt_nxt  = vcnt_e;
    rstat_nxt = rstat_e;
    class_nxt = class_e;
    meta_nxt  = meta_e;
    left_nxt  = left_e;
    cstat_nxt = cstat_e;
    elen_nxt  = elen_e;
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;
    end_ev    = 1'b0;
    clen      = chan_len(rstat_e);

    case (phase_e)
      PH_DELTA: begin
        if (vlq_ovf) begin
          // A number cut off by its byte count keeps the group just taken; one too wide does not
          res0 = make_res(KIND_ERROR, class_e, cstat_e, meta_e,
                          vlq_wide ? delta_e : vlq_new, '0, 8'd0,
                          1'b1, ERR_OVERFLOW);
          n_res = 2'd1;
          phase_nxt = PH_HALT;
        end else begin
          delta_nxt = vlq_new;
          if (b[7]) begin
            vcnt_nxt = vcnt_e + VlqCntW'(1);
          end else begin
            vcnt_nxt  = '0;
            phase_nxt = PH_STATUS;
          end
        end
      end

      PH_STATUS: begin
        if (!b[7]) begin
          // Running status: header and first data byte together
          if (rstat_e == '0) begin
            res0 = make_res(KIND_ERROR, class_e, cstat_e, meta_e, delta_e, '0, 8'd0,
                            1'b1, ERR_NO_RSTAT);
            n_res = 2'd1;
            phase_nxt = PH_HALT;
          end else begin
            cstat_nxt = rstat_e;
            class_nxt = CLASS_CHAN;
            elen_nxt  = NumW'(clen);
            res0 = make_res(KIND_HEADER, CLASS_CHAN, rstat_e, meta_e, delta_e,
                            NumW'(clen), 8'd0, 1'b0, ERR_NONE);
            res1 = make_res(KIND_PAYLOAD, CLASS_CHAN, rstat_e, meta_e, delta_e,
                            NumW'(clen), b, clen == 2'd1, ERR_NONE);
            n_res = 2'd2;
            if (clen == 2'd1) begin
              end_ev = 1'b1;
            end else begin
              left_nxt  = NumW'(1);
              phase_nxt = PH_DATA;
            end
          end
        end else if (b < ST_SYSTEM) begin
          cstat_nxt = b;
          rstat_nxt = b;
          class_nxt = CLASS_CHAN;
          elen_nxt  = NumW'(chan_len(b));
          left_nxt  = NumW'(chan_len(b));
          res0 = make_res(KIND_HEADER, CLASS_CHAN, b, meta_e, delta_e,
                          NumW'(chan_len(b)), 8'd0, 1'b0, ERR_NONE);
          n_res = 2'd1;
          phase_nxt = PH_DATA;
        end else if (b == ST_META) begin
          cstat_nxt = b;
          rstat_nxt = '0;
          class_nxt = CLASS_META;
          phase_nxt = PH_MTYPE;
        end else if (b == ST_SYSEX || b == ST_ESCAPE) begin
          cstat_nxt = b;
          rstat_nxt = '0;
          class_nxt = CLASS_SYSEX;
          left_nxt  = '0;
          vcnt_nxt  = '0;
          phase_nxt = PH_LEN;
        end else begin
          cstat_nxt = b;
          res0 = make_res(KIND_ERROR, class_e, b, meta_e, delta_e, '0, 8'd0,
                          1'b1, ERR_UNKNOWN);
          n_res = 2'd1;
          phase_nxt = PH_HALT;
        end
      end

      PH_MTYPE: begin
        meta_nxt = b;
        if (!mi_in.known) begin
          res0 = make_res(KIND_ERROR, class_e, cstat_e, b, delta_e, '0, 8'd0,
                          1'b1, ERR_UNKNOWN);
          n_res = 2'd1;
          phase_nxt = PH_HALT;
        end else begin
          left_nxt  = '0;
          vcnt_nxt  = '0;
          phase_nxt = PH_LEN;
        end
      end

      PH_LEN: begin
        if (vlq_ovf) begin
          res0 = make_res(KIND_ERROR, class_e, cstat_e, meta_e, delta_e, '0, 8'd0,
                          1'b1, ERR_OVERFLOW);
          n_res = 2'd1;
          phase_nxt = PH_HALT;
        end else if (b[7]) begin
          left_nxt = vlq_new;
          vcnt_nxt = vcnt_e + VlqCntW'(1);
        end else if (class_e == CLASS_META && mi.known && !mi.var_len &&
                     vlq_new != NumW'(mi.len)) begin
          left_nxt = vlq_new;
          vcnt_nxt = '0;
          res0 = make_res(KIND_ERROR, class_e, cstat_e, meta_e, delta_e, '0, 8'd0,
                          1'b1, ERR_META_LEN);
          n_res = 2'd1;
          phase_nxt = PH_HALT;
        end else begin
          left_nxt = vlq_new;
          vcnt_nxt = '0;
          elen_nxt = vlq_new;
          res0 = make_res(KIND_HEADER, class_e, cstat_e, meta_e, delta_e, vlq_new,
                          8'd0, vlq_new == '0, ERR_NONE);
          n_res = 2'd1;
          if (vlq_new == '0) begin
            end_ev = 1'b1;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end

      PH_DATA: begin
        left_nxt = left_dec;
        res0 = make_res(KIND_PAYLOAD, class_e, cstat_e, meta_e, delta_e, elen_e, b,
                        left_dec == '0, ERR_NONE);
        n_res = 2'd1;
        end_ev = (left_dec == '0);
      end

      default: begin
        // Halted: drop bytes until a new track starts
      end
    endcase

    // Close the event: halt on end of track, else clear for the next one
    if (end_ev) begin
      if (class_nxt == CLASS_META && meta_nxt == META_EOT) begin
        phase_nxt = PH_HALT;
      end else begin
        phase_nxt = PH_DELTA;
        delta_nxt = '0;
        vcnt_nxt  = '0;
        class_nxt = CLASS_CHAN;
        meta_nxt  = '0;
        left_nxt  = '0;
        cstat_nxt = '0;
        elen_nxt  = '0;
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      delta_r <= '0;
      vcnt_r  <= '0;
      rstat_r <= '0;
      class_r <= CLASS_CHAN;
      meta_r  <= '0;
      left_r  <= '0;
      cstat_r <= '0;
      elen_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      delta_r <= delta_nxt;
      vcnt_r  <= vcnt_nxt;
      rstat_r <= rstat_nxt;
      class_r <= class_nxt;
      meta_r  <= meta_nxt;
      left_r  <= left_nxt;
      cstat_r <= cstat_nxt;
      elen_r  <= elen_nxt;
    end
  end

  // Result queue
  assign in_tready = (count_r <= 3'd2);
  assign pop       = out_tvalid && out_tready;
  assign n_push    = accept ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_push;
      rd_ptr_r <= rd_ptr_r + 2'(pop);
      count_r  <= count_r + 3'(n_push) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  // Present the oldest result
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (count_r != 3'd0);
  assign out_tdata  = {4'd0, head.err, head.eot, head.pbyte, head.plen, head.delta,
                       head.meta, head.status};
  assign out_tuser  = {head.evclass, head.kind};
  assign out_tlast  = head.last;

endmodule
